### hdl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 message hasher.
package sha256_pkg;

  localparam int unsigned RoundW = 6;
  localparam int unsigned FillW  = 6;
  localparam int unsigned TotalW = 61;
  localparam int unsigned IdxW   = 3;

  localparam logic [7:0]        PadMarker = 8'h80;
  localparam logic [7:0]        PadZero   = 8'h00;
  localparam logic [FillW-1:0]  LenStart  = 6'd56;
  localparam logic [FillW-1:0]  LastFill  = 6'd63;
  localparam logic [RoundW-1:0] LastRound = 6'd63;
  localparam logic [IdxW-1:0]   LastWord  = 3'd7;

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              push;
    logic [7:0]        push_byte;
    logic              load;
    logic              round;
    logic              add;
    logic              rearm;
    logic [RoundW-1:0] rnd;
    logic [IdxW-1:0]   oidx;
  } ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### hdl/sha256_in_if.sv
// Message byte channel.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

### hdl/sha256_out_if.sv
// Digest word channel.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha256_ctrl.sv
// Sequencer: byte intake, padding, length append, round count and digest readout.
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               msg_valid_i,
  input  logic [7:0]         msg_byte_i,
  input  logic               msg_has_byte_i,
  input  logic               msg_eom_i,
  output logic               msg_ready_o,
  output logic               dig_valid_o,
  input  logic               dig_ready_i,
  output logic               dig_last_o,
  output sha256_pkg::ctrl_t  ctl_o
);
  import sha256_pkg::*;

  state_e             state_q, state_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [RoundW-1:0]  rnd_q, rnd_d;
  logic [IdxW-1:0]    oidx_q, oidx_d;
  logic               pad_q, pad_d;
  logic               mark_q, mark_d;
  logic               fin_q, fin_d;

  logic               acc;
  logic               full;
  logic [63:0]        len_bits;
  logic [7:0]         len_byte;

  // Length goes out big-endian: fill 56 carries the top byte.
  assign len_bits = {total_q, 3'b000};
  assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];

  assign acc  = msg_valid_i & msg_ready_o;
  assign full = ctl_o.push & (fill_q == LastFill);

  // Outputs
  always_comb begin
    msg_ready_o     = (state_q == ST_IDLE);
    dig_valid_o     = (state_q == ST_OUT);
    dig_last_o      = (oidx_q == LastWord);
    ctl_o.push      = 1'b0;
    ctl_o.push_byte = msg_byte_i;
    ctl_o.load      = (state_q == ST_LOAD);
    ctl_o.round     = (state_q == ST_ROUND);
    ctl_o.add       = (state_q == ST_ADD);
    ctl_o.rearm     = (state_q == ST_OUT) & dig_ready_i & (oidx_q == LastWord);
    ctl_o.rnd       = rnd_q;
    ctl_o.oidx      = oidx_q;
    case (state_q)
      ST_IDLE: begin
        ctl_o.push = (msg_valid_i & msg_has_byte_i);
      end
      ST_PAD: begin
        ctl_o.push      = !mark_q || (fill_q != LenStart);
        ctl_o.push_byte = mark_q ? PadZero : PadMarker;
      end
      ST_LEN: begin
        ctl_o.push      = 1'b1;
        ctl_o.push_byte = len_byte;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (full) begin
            state_d = ST_LOAD;
          end else if (msg_eom_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (full) begin
          state_d = ST_LOAD;
        end else if (mark_q && fill_q == LenStart) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (full) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fin_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (dig_ready_i && oidx_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters and flags
  always_comb begin
    fill_d  = ctl_o.push ? fill_q + 6'd1 : fill_q;
    total_d = total_q;
    rnd_d   = ctl_o.round ? rnd_q + 6'd1 : rnd_q;
    oidx_d  = (dig_valid_o && dig_ready_i) ? oidx_q + 3'd1 : oidx_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    fin_d   = fin_q;
    if (state_q == ST_IDLE && ctl_o.push) begin
      total_d = total_q + 61'd1;
    end
    if (acc && msg_eom_i) begin
      pad_d = 1'b1;
    end
    if (state_q == ST_PAD && !mark_q) begin
      mark_d = 1'b1;
    end
    if (state_q == ST_LEN && full) begin
      fin_d = 1'b1;
    end
    if (ctl_o.rearm) begin
      fill_d  = '0;
      total_d = '0;
      pad_d   = 1'b0;
      mark_d  = 1'b0;
      fin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      fin_q   <= fin_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && rnd_q == LastRound |=> state_q == ST_ADD)
    else $error("round sequence did not end in the add step");

  a_round_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> rnd_q == '0)
    else $error("round counter not at zero when a block starts");

  a_len_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LEN |-> fill_q[5:3] == 3'b111)
    else $error("length bytes placed outside the block tail");

  a_out_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> fin_q && mark_q && fill_q == '0)
    else $error("digest shown before the final block was compressed");
`endif

endmodule

### hdl/sha256_sched.sv
// Block buffer and rolling message schedule: byte shift-in, one new word per round.
module sha256_sched (
  input  logic              clk_i,
  input  sha256_pkg::ctrl_t ctl_i,
  output logic [31:0]       wt_o
);
  import sha256_pkg::*;

  logic [31:0] w_q [0:15];
  logic [31:0] w_d [0:15];
  logic [31:0] w_next;

  assign w_next = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
  assign wt_o   = w_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    if (ctl_i.push) begin
      // Shift the whole 512-bit window up by one byte.
      for (int i = 0; i < 15; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[15] = {w_q[15][23:0], ctl_i.push_byte};
    end else if (ctl_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_next;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
  end

endmodule

### hdl/sha256_round.sv
// Compression round unit, working variables and chaining words.
module sha256_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha256_pkg::ctrl_t ctl_i,
  input  logic [31:0]       wt_i,
  output logic [31:0]       digest_word_o
);
  import sha256_pkg::*;

  logic [31:0] hash_q [0:7];
  logic [31:0] hash_d [0:7];
  logic [31:0] work_q [0:7];
  logic [31:0] work_d [0:7];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + big_sig1(work_q[4]) + ch + ROUND_K[ctl_i.rnd] + wt_i;
  assign t2  = big_sig0(work_q[0]) + maj;

  assign digest_word_o = hash_q[ctl_i.oidx];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      work_d[i] = work_q[i];
      hash_d[i] = hash_q[i];
    end
    if (ctl_i.load) begin
      for (int i = 0; i < 8; i++) begin
        work_d[i] = hash_q[i];
      end
    end else if (ctl_i.round) begin
      work_d[0] = t1 + t2;
      work_d[1] = work_q[0];
      work_d[2] = work_q[1];
      work_d[3] = work_q[2];
      work_d[4] = work_q[3] + t1;
      work_d[5] = work_q[4];
      work_d[6] = work_q[5];
      work_d[7] = work_q[6];
    end
    if (ctl_i.add) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end else if (ctl_i.rearm) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = SHA_IV[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      work_q[i] <= work_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= SHA_IV[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_d[i];
      end
    end
  end

endmodule

### hdl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
//
//   channel  dir  payload                                  items
//   msg_i    in   data_byte, has_byte, end_of_message      one per message byte
//   dig_o    out  digest_word, word_index, last_word       eight per message
//
// An item that neither fills a block nor ends the message leaves msg_i ready.
// A byte that fills the block runs load, 64 rounds on the single round unit and
// the chaining add. End of message feeds pad and length bytes to the buffer one
// per cycle outside one or two compressions, then shows the eight digest words,
// one per cycle while dig_o is ready; msg_i stays not ready until the last word
// is taken. Reset restores the initial hash value; no clearing pass is needed.
module sha256_message_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    msg_i,
  sha256_out_if.source dig_o
);
  import sha256_pkg::*;

  ctrl_t       ctl;
  logic [31:0] wt;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_valid_i    (msg_i.valid),
    .msg_byte_i     (msg_i.data_byte),
    .msg_has_byte_i (msg_i.has_byte),
    .msg_eom_i      (msg_i.end_of_message),
    .msg_ready_o    (msg_i.ready),
    .dig_valid_o    (dig_o.valid),
    .dig_ready_i    (dig_o.ready),
    .dig_last_o     (dig_o.last_word),
    .ctl_o          (ctl)
  );

  sha256_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .wt_o  (wt)
  );

  sha256_round u_round (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .wt_i          (wt),
    .digest_word_o (digest_word)
  );

  assign dig_o.digest_word = digest_word;
  assign dig_o.word_index  = ctl.oidx;

endmodule

### test/sha256_message_hasher_tb.sv
// Testbench for the SHA-256 message hasher: random messages checked against a digest predictor.
`timescale 1ns / 1ps

module sha256_message_hasher_tb;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_OFFSET  = 56;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam logic [7:0]  END_MARK    = 8'h80;
  localparam logic [2:0]  FINAL_IDX   = 3'd7;

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Predicts the digest words of each message and checks them in order.
  class digest_board;
    logic [31:0]  chain [8];
    logic [511:0] held;
    int unsigned  fill;
    logic [60:0]  total;
    digest_word_t due [$];
    int unsigned  faults;

    function void restart();
      for (int k = 0; k < 8; k++) chain[k] = START_HASH[k];
      held  = '0;
      fill  = 0;
      total = '0;
    endfunction

    function logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(input logic [511:0] blk);
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, w15, w2;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
        if (i >= 16) begin
          w15 = w[(i - 15) % 16];
          w2  = w[(i - 2) % 16];
          s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
          s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
          w[i % 16] = w[i % 16] + s0 + w[(i - 7) % 16] + s1;
        end
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_CONST[i] + w[i % 16];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void take_item(input logic [7:0] data, input logic has, input logic eom);
      logic [1023:0] tail;
      logic [63:0]   bits;
      digest_word_t  dw;
      if (has) begin
        held[511 - 8 * fill -: 8] = data;
        fill++;
        total++;
        // A full block compresses at once.
        if (fill == BLOCK_BYTES) begin
          compress(held);
          fill = 0;
        end
      end
      if (!eom) return;
      tail = '0;
      for (int k = 0; k < fill; k++) tail[1023 - 8 * k -: 8] = held[511 - 8 * k -: 8];
      tail[1023 - 8 * fill -: 8] = END_MARK;
      bits = {total, 3'b000};
      if (fill < LEN_OFFSET) begin
        tail[575:512] = bits;
        compress(tail[1023:512]);
      end else begin
        tail[63:0] = bits;
        compress(tail[1023:512]);
        compress(tail[511:0]);
      end
      for (int k = 0; k < 8; k++) begin
        dw.word = chain[k];
        dw.idx  = 3'(k);
        dw.last = (3'(k) == FINAL_IDX);
        due.push_back(dw);
      end
      restart();
    endfunction

    function void check_word(input digest_word_t got);
      digest_word_t want;
      if (due.size() == 0) begin
        $display("%0t: digest word with none expected: expected none, got %h idx %0d last %0b",
                 $time, got.word, got.idx, got.last);
        faults++;
        return;
      end
      want = due.pop_front();
      if (got.word !== want.word || got.idx !== want.idx || got.last !== want.last) begin
        $display("%0t: digest word mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                 $time, want.word, want.idx, want.last, got.word, got.idx, got.last);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sha256_in_if  msg_if ();
  sha256_out_if dig_if ();

  sha256_message_hasher i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg_if),
    .dig_o (dig_if)
  );

  digest_board board;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: stall at random, per phase.
  initial begin
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      dig_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      board.check_word('{word: dig_if.digest_word, idx: dig_if.word_index,
                         last: dig_if.last_word});
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= data;
    msg_if.has_byte       <= has;
    msg_if.end_of_message <= eom;
    do @(posedge clk_i); while (!msg_if.ready);
    board.take_item(data, has, eom);
    @(negedge clk_i);
  endtask

  // One message of len bytes, with a few ignored items mixed in.
  task automatic send_message(input int unsigned len);
    logic end_on_byte;
    end_on_byte = (len != 0) && $urandom_range(1);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
    end
    if (!end_on_byte) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Near the padding limit and the block size, or a short message.
  function automatic int unsigned pick_length(input logic near_block);
    if (near_block) begin
      return $urandom_range(LEN_OFFSET - 1, BLOCK_BYTES + 1);
    end
    return $urandom_range(12);
  endfunction

  initial begin
    board = new;
    board.restart();
    board.faults  = 0;
    cycles        = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'h00;
    msg_if.has_byte       = 1'b0;
    msg_if.end_of_message = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty message, an ignored item, then another empty message.
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // "abc", ending on its last byte.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Single extreme bytes, ended apart and on the byte.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 82; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 82; end
        default: begin in_idle_pct = 24; out_stall_pct = 24; end
      endcase
      send_message(pick_length(ph == 0));
      send_message(pick_length(1'b0));
    end
    msg_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sha256_pkg.sv
hdl/sha256_in_if.sv
hdl/sha256_out_if.sv
hdl/sha256_ctrl.sv
hdl/sha256_sched.sv
hdl/sha256_round.sv
hdl/sha256_message_hasher.sv
test/sha256_message_hasher_tb.sv
